@@ rtl/tffe_pkg.sv @@
package tffe_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int MAX_DESC_DEF    = 8;

  localparam logic [7:0] SYNC_RESET   = 8'hCA;
  localparam logic [7:0] ADD_DESC_CMD = 8'h88;
  localparam int         PLOT_BIT     = 7;

  // byte positions in the frame store
  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_SYNC     = 9'd0;
  localparam logic [POS_W-1:0] POS_LEN      = 9'd1;
  localparam logic [POS_W-1:0] POS_CMD      = 9'd2;
  localparam logic [POS_W-1:0] PAYLOAD_BASE = 9'd3;
  localparam logic [POS_W-1:0] POS_X        = 9'd3;
  localparam logic [POS_W-1:0] POS_Y        = 9'd5;

  // field fetch step count: four byte reads through the registered read ports
  localparam logic [2:0] FIELD_DONE = 3'd4;

  typedef struct packed {
    logic wr_sync;
    logic wr_len;
    logic wr_cmd;
    logic wr_data;
    logic desc_rd;
    logic desc_wr;
    logic fld_start;
    logic fld_step;
    logic max_upd;
    logic out_load;
    logic k_clr;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic is_sync;
    logic short_len;
    logic data_last;
    logic is_add;
    logic is_plot;
    logic table_full;
    logic no_desc;
    logic fld_done;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/tffe_ctrl.sv @@
module tffe_ctrl
  import tffe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_SYNC,
    S_LEN,
    S_CMD,
    S_DATA,
    S_FIN,
    S_DRD,
    S_DWR,
    S_RD,
    S_MAX,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SYNC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_SYNC: begin
        in_ready = 1'b1;
        if (in_valid && sts.is_sync) begin
          cmd.wr_sync = 1'b1;
          state_next  = S_LEN;
        end
      end
      S_LEN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_len = 1'b1;
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_cmd = 1'b1;
          state_next = sts.short_len ? S_FIN : S_DATA;
        end
      end
      S_DATA: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_data = 1'b1;
          if (sts.data_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd.k_clr     = 1'b1;
        cmd.fld_start = 1'b1;
        if (sts.is_add) begin
          state_next = sts.table_full ? S_SYNC : S_DRD;
        end else if (sts.is_plot && !sts.no_desc) begin
          state_next = S_RD;
        end else begin
          state_next = S_SYNC;
        end
      end
      S_DRD: begin
        cmd.desc_rd = 1'b1;
        state_next  = S_DWR;
      end
      S_DWR: begin
        cmd.desc_wr = 1'b1;
        state_next  = S_SYNC;
      end
      S_RD: begin
        cmd.fld_step = 1'b1;
        if (sts.fld_done) begin
          state_next = S_MAX;
        end
      end
      S_MAX: begin
        cmd.max_upd = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.k_last) begin
            state_next = S_SYNC;
          end else begin
            cmd.k_inc     = 1'b1;
            cmd.fld_start = 1'b1;
            state_next    = S_RD;
          end
        end
      end
      default: begin
        state_next = S_SYNC;
      end
    endcase
  end

endmodule

@@ rtl/tffe_dp.sv @@
module tffe_dp
  import tffe_pkg::*;
#(
  parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
  parameter int MAX_DESCRIPTORS = MAX_DESC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [7:0]         rx_byte,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         descriptor_index,
  output logic [31:0]        time_value,
  output logic signed [31:0] temperature_value,
  output logic signed [31:0] peak_temp,
  output logic               last_of_frame
);

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CW = $clog2(MAX_DESCRIPTORS + 1);
  localparam int IW = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;

  logic [7:0]         sync_byte;
  logic [7:0]         frame_length;
  logic [7:0]         command_code;
  logic [7:0]         payload_count;
  logic [7:0]         frame_store [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] store_vld;
  logic [7:0]         x_offsets [MAX_DESCRIPTORS];
  logic [7:0]         y_offsets [MAX_DESCRIPTORS];
  logic [CW-1:0]      descriptor_count;
  logic [CW-1:0]      k;
  logic [2:0]         fld_j;
  logic [7:0]         rda_data, rdb_data;
  logic               rda_zero, rdb_zero;
  logic [31:0]        time_acc;
  logic signed [31:0] temp_acc;
  logic signed [31:0] running_max;

  logic               wr_en, wr_in;
  logic [POS_W-1:0]   wr_pos, rda_pos, rdb_pos;
  logic [IW-1:0]      kidx;
  logic [7:0]         a_byte, b_byte;

  assign kidx   = k[IW-1:0];
  assign a_byte = rda_zero ? 8'h00 : rda_data;
  assign b_byte = rdb_zero ? 8'h00 : rdb_data;

  always_comb begin
    wr_en  = 1'b0;
    wr_pos = POS_SYNC;
    if (cmd.wr_sync) begin
      wr_en  = 1'b1;
      wr_pos = POS_SYNC;
    end else if (cmd.wr_len) begin
      wr_en  = 1'b1;
      wr_pos = POS_LEN;
    end else if (cmd.wr_cmd) begin
      wr_en  = 1'b1;
      wr_pos = POS_CMD;
    end else if (cmd.wr_data) begin
      wr_en  = 1'b1;
      wr_pos = PAYLOAD_BASE + {1'b0, payload_count};
    end
  end

  assign wr_in = wr_en && (wr_pos < POS_W'(FRAME_BYTES));

  always_comb begin
    if (cmd.desc_rd) begin
      rda_pos = POS_X;
      rdb_pos = POS_Y;
    end else begin
      rda_pos = {1'b0, x_offsets[kidx]} + PAYLOAD_BASE + POS_W'(fld_j);
      rdb_pos = {1'b0, y_offsets[kidx]} + PAYLOAD_BASE + POS_W'(fld_j);
    end
  end

  // frame store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_in) begin
      frame_store[wr_pos[AW-1:0]] <= rx_byte;
    end
    rda_data <= frame_store[rda_pos[AW-1:0]];
    rdb_data <= frame_store[rdb_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
    end else if (wr_in) begin
      store_vld[wr_pos[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rda_zero <= !(rda_pos < POS_W'(FRAME_BYTES)) || !store_vld[rda_pos[AW-1:0]];
    rdb_zero <= !(rdb_pos < POS_W'(FRAME_BYTES)) || !store_vld[rdb_pos[AW-1:0]];
    if (cmd.desc_wr) begin
      x_offsets[descriptor_count[IW-1:0]] <= a_byte;
      y_offsets[descriptor_count[IW-1:0]] <= b_byte;
    end
    if (cmd.fld_step && (fld_j != 3'd0)) begin
      time_acc <= {a_byte, time_acc[31:8]};
      temp_acc <= {b_byte, temp_acc[31:8]};
    end
    if (cmd.out_load) begin
      descriptor_index  <= 3'(k);
      time_value        <= time_acc;
      temperature_value <= temp_acc;
      peak_temp         <= running_max;
      last_of_frame     <= sts.k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte        <= SYNC_RESET;
      frame_length     <= '0;
      command_code     <= '0;
      payload_count    <= '0;
      descriptor_count <= '0;
      running_max      <= '0;
      k                <= '0;
      fld_j            <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        sync_byte <= cfg_data;
      end
      if (cmd.wr_len) begin
        frame_length  <= rx_byte;
        payload_count <= '0;
      end
      if (cmd.wr_cmd) begin
        command_code <= rx_byte;
      end
      if (cmd.wr_data) begin
        payload_count <= payload_count + 8'd1;
      end
      if (cmd.desc_wr) begin
        descriptor_count <= descriptor_count + CW'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + CW'(1);
      end
      if (cmd.fld_start) begin
        fld_j <= '0;
      end else if (cmd.fld_step) begin
        fld_j <= fld_j + 3'd1;
      end
      if (cmd.max_upd && (temp_acc > running_max)) begin
        running_max <= temp_acc;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_sync    = (rx_byte == sync_byte);
    sts.short_len  = (frame_length <= 8'd2);
    sts.data_last  = (({1'b0, payload_count} + 9'd1) >= ({1'b0, frame_length} - 9'd2));
    sts.is_add     = (command_code == ADD_DESC_CMD);
    sts.is_plot    = command_code[PLOT_BIT];
    sts.table_full = (descriptor_count == CW'(MAX_DESCRIPTORS));
    sts.no_desc    = (descriptor_count == '0);
    sts.fld_done   = (fld_j == FIELD_DONE);
    sts.k_last     = ((k + CW'(1)) == descriptor_count);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/telemetry_frame_field_extractor.sv @@
// Parses a byte stream of frames (sync, length, command, payload) into a frame
// store and, at the end of a plotting frame, emits one result per stored point
// descriptor with its time, temperature and the running maximum temperature.
// Each byte is taken in one cycle while a frame is being received. The end of a
// descriptor frame (command 0x88) runs the finish, descriptor read and write states
// before the next byte is taken, or finish alone when the table is full; a plotting
// frame runs the field reads, maximum update and emit for each stored descriptor,
// emit waiting while the result consumer stalls; any other frame runs finish alone.
// The field sequencer reads one byte of time and one byte of temperature per cycle
// through the two read ports of the frame store. The sync byte register resets to
// 0xCA; the frame store reads as zero until written after reset.
module telemetry_frame_field_extractor
  import tffe_pkg::*;
#(
  parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
  parameter int MAX_DESCRIPTORS = MAX_DESC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         descriptor_index,
  output logic [31:0]        time_value,
  output logic signed [31:0] temperature_value,
  output logic signed [31:0] peak_temp,
  output logic               last_of_frame
);

  cmd_t cmd;
  sts_t sts;

  tffe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tffe_dp #(
    .FRAME_BYTES     (FRAME_BYTES),
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .rx_byte           (rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .descriptor_index  (descriptor_index),
    .time_value        (time_value),
    .temperature_value (temperature_value),
    .peak_temp         (peak_temp),
    .last_of_frame     (last_of_frame)
  );

endmodule

@@ rtl/tffe_checker.sv @@
module tffe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         descriptor_index,
  input logic [31:0]        time_value,
  input logic signed [31:0] temperature_value,
  input logic signed [31:0] peak_temp,
  input logic               last_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(descriptor_index) &&
      $stable(time_value) && $stable(temperature_value) &&
      $stable(peak_temp) && $stable(last_of_frame))
    else $error("result changed while stalled");

  a_max_covers_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_temp >= temperature_value)
    else $error("max below temperature");

  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid || (peak_temp >= $past(peak_temp)))
    else $error("running max decreased");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind telemetry_frame_field_extractor tffe_checker u_tffe_checker (.*);

@@ dv/tb_telemetry_frame_field_extractor.sv @@
`timescale 1ns / 100ps

module tb_telemetry_frame_field_extractor;
  import tffe_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES = 100;

  typedef enum logic [1:0] {HUNT, GET_LEN, GET_CMD, GET_DATA} hunt_t;

  typedef struct packed {
    logic [2:0]         idx;
    logic [31:0]        tval;
    logic signed [31:0] temp;
    logic signed [31:0] tmax;
    logic               fin;
  } point_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    point_t     want;
  } dir_row_t;

  localparam point_t NO_POINT = '0;
  localparam point_t NEG_EXTREME = '{idx: 3'd0, tval: 32'h8000_0000,
                                     temp: 32'sh8000_0000, tmax: 32'sd0, fin: 1'b1};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_data = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         descriptor_index;
  logic [31:0]        time_value;
  logic signed [31:0] temperature_value;
  logic signed [31:0] peak_temp;
  logic               last_of_frame;

  telemetry_frame_field_extractor u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .descriptor_index  (descriptor_index),
    .time_value        (time_value),
    .temperature_value (temperature_value),
    .peak_temp         (peak_temp),
    .last_of_frame     (last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame parser state mirrored in the bench
  hunt_t              pstate = HUNT;
  logic [7:0]         sync_cur = SYNC_RESET;
  logic [7:0]         flen, fcmd, pcount;
  logic [7:0]         fstore [FRAME_BYTES_DEF];
  logic [7:0]         xoff [MAX_DESC_DEF];
  logic [7:0]         yoff [MAX_DESC_DEF];
  int                 dcount = 0;
  logic signed [31:0] rmax = '0;
  int                 full_drops = 0;

  point_t frame_out [$];
  point_t pending_points [$];
  int     points_made = 0;
  int     sent = 0;
  int     long_left = 2;
  int     mism = 0;
  int     quiet = 0;
  int     hold_left = 0;
  bit     hold_req = 1'b0;
  bit     steady = 1'b0;

  // sync, length, command, payload
  dir_row_t dir_rows [27] = '{
    {8'h00, 1'b0, NO_POINT},
    {8'hCA, 1'b0, NO_POINT}, {8'h00, 1'b0, NO_POINT}, {8'h80, 1'b0, NO_POINT},
    {8'hCA, 1'b0, NO_POINT}, {8'h02, 1'b0, NO_POINT}, {8'h88, 1'b0, NO_POINT},
    {8'hCA, 1'b0, NO_POINT}, {8'h06, 1'b0, NO_POINT}, {8'h81, 1'b0, NO_POINT},
    {8'h00, 1'b0, NO_POINT}, {8'h00, 1'b0, NO_POINT}, {8'h00, 1'b0, NO_POINT},
    {8'h80, 1'b1, NEG_EXTREME},
    {8'hCA, 1'b0, NO_POINT}, {8'h03, 1'b0, NO_POINT}, {8'h7F, 1'b0, NO_POINT},
    {8'h55, 1'b0, NO_POINT},
    {8'hCA, 1'b0, NO_POINT}, {8'h01, 1'b0, NO_POINT}, {8'hFF, 1'b0, NO_POINT},
    {8'hCA, 1'b0, NO_POINT}, {8'h05, 1'b0, NO_POINT}, {8'h88, 1'b0, NO_POINT},
    {8'h3C, 1'b0, NO_POINT}, {8'h00, 1'b0, NO_POINT}, {8'h01, 1'b0, NO_POINT}
  };

  function automatic logic [7:0] store_at(input int pos);
    return (pos < FRAME_BYTES_DEF) ? fstore[pos] : 8'h00;
  endfunction

  function automatic logic [31:0] le32_at(input int pos);
    return {store_at(pos + 3), store_at(pos + 2), store_at(pos + 1), store_at(pos)};
  endfunction

  function automatic void close_frame();
    logic [31:0] t, traw;
    point_t      p;
    pstate = HUNT;
    if (fcmd == ADD_DESC_CMD) begin
      if (dcount < MAX_DESC_DEF) begin
        xoff[dcount] = store_at(int'(POS_X));
        yoff[dcount] = store_at(int'(POS_Y));
        dcount++;
      end else begin
        full_drops++;
      end
    end else if (fcmd[PLOT_BIT]) begin
      for (int k = 0; k < dcount; k++) begin
        t = le32_at(int'(xoff[k]) + int'(PAYLOAD_BASE));
        traw = le32_at(int'(yoff[k]) + int'(PAYLOAD_BASE));
        if ($signed(traw) > rmax) rmax = $signed(traw);
        p.idx = 3'(k);
        p.tval = t;
        p.temp = $signed(traw);
        p.tmax = rmax;
        p.fin = (k + 1 == dcount);
        frame_out.insert(frame_out.size(), p);
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int pos;
    frame_out.delete();
    case (pstate)
      HUNT: begin
        if (b == sync_cur) begin
          fstore[POS_SYNC] = b;
          pstate = GET_LEN;
        end
      end
      GET_LEN: begin
        flen = b;
        fstore[POS_LEN] = b;
        pcount = 8'd0;
        pstate = GET_CMD;
      end
      GET_CMD: begin
        fcmd = b;
        fstore[POS_CMD] = b;
        if (flen <= 8'd2) close_frame();
        else pstate = GET_DATA;
      end
      default: begin
        pos = int'(PAYLOAD_BASE) + int'(pcount);
        if (pos < FRAME_BYTES_DEF) fstore[pos] = b;
        pcount++;
        if (int'(pcount) >= int'(flen) - 2) close_frame();
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input point_t want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    parse_byte(b);
    if (typed) begin
      pending_points.insert(pending_points.size(), want);
      points_made++;
    end else begin
      foreach (frame_out[i]) pending_points.insert(pending_points.size(), frame_out[i]);
      points_made += frame_out.size();
    end
  endtask

  task automatic send_rand(input logic [7:0] b);
    send_byte(b, 1'b0, NO_POINT);
  endtask

  task automatic send_frame(input logic [7:0] syncv);
    int         kind, len;
    logic [7:0] cmd, b, xo, yo;
    kind = $urandom_range(99);
    if (kind < 8) begin
      b = 8'($urandom_range(255));
      while (b == syncv) b = 8'($urandom_range(255));
      send_rand(b);
      return;
    end
    if (kind >= 93) begin
      repeat ($urandom_range(1, 6)) send_rand(8'($urandom_range(255)));
      return;
    end
    if (kind < 40) begin
      cmd = ADD_DESC_CMD;
      len = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
    end else if (kind < 82) begin
      cmd = 8'h80 | 8'($urandom_range(127));
      while (cmd == ADD_DESC_CMD) cmd = 8'h80 | 8'($urandom_range(127));
      if (long_left > 0 && $urandom_range(14) == 0) begin
        len = $urandom_range(64, 90);
        long_left--;
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(2);
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(3, 46) : $urandom_range(3, 20);
      end
    end else begin
      cmd = 8'($urandom_range(127));
      len = $urandom_range(12);
    end
    xo = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
    yo = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
    send_rand(syncv);
    send_rand(8'(len));
    send_rand(cmd);
    for (int i = 0; i < len - 2; i++) begin
      b = 8'($urandom_range(255));
      if (cmd == ADD_DESC_CMD && i == 0) b = xo;
      if (cmd == ADD_DESC_CMD && i == 2) b = yo;
      send_rand(b);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    sync_cur = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{descriptor_index, time_value, temperature_value, peak_temp,
              last_of_frame};
      if (pending_points.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected result: idx %0d time %h temp %0d max %0d last %b",
                   got.idx, got.tval, got.temp, got.tmax, got.fin);
      end else begin
        want = pending_points.pop_front();
        if (got !== want) begin
          mism++;
          if (mism <= 10)
            $display("exp/act idx %0d/%0d time %h/%h temp %0d/%0d max %0d/%0d last %b/%b",
                     want.idx, got.idx, want.tval, got.tval, want.temp, got.temp,
                     want.tmax, got.tmax, want.fin, got.fin);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [7:0] syncs [4];
    int         mark;
    foreach (fstore[i]) fstore[i] = 8'h00;
    foreach (xoff[i]) begin
      xoff[i] = 8'h00;
      yoff[i] = 8'h00;
    end
    syncs = '{8'h00, 8'hFF, 8'($urandom_range(255)), SYNC_RESET};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_sync(syncs[ph]);
      // long receiver stall while items keep coming
      if (ph == 0) hold_req = 1'b1;
      steady = (ph == 1);
      mark = sent;
      while (sent - mark < 50 ||
             (ph == 3 && (sent < 227 || full_drops < 2 || points_made < 48)))
        send_frame(syncs[ph]);
      while (pstate != HUNT) send_rand(8'($urandom_range(255)));
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mism == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tffe_pkg.sv
rtl/tffe_ctrl.sv
rtl/tffe_dp.sv
rtl/telemetry_frame_field_extractor.sv
rtl/tffe_checker.sv
dv/tb_telemetry_frame_field_extractor.sv
